// ===== rtl/core/fsif_pkg.sv =====
// ----------------------------------------------------------------------------
// fsif_pkg
// Shared constants, control word layout and microcode table of the
// format string integer formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fsif_pkg;

    localparam int ARG_BITS   = 32;
    localparam int DEC_DIGITS = ((ARG_BITS * 1233) >> 12) + 1;
    localparam int WORK_BITS  = 4 * DEC_DIGITS;
    localparam int CNT_BITS   = $clog2(ARG_BITS + 1);
    localparam int IDX_BITS   = $clog2(ARG_BITS);
    localparam int STEP_BITS  = 4;

    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UA    = 8'h41;

    // character source
    localparam logic [2:0] EM_NONE  = 3'd0;
    localparam logic [2:0] EM_FMT   = 3'd1;
    localparam logic [2:0] EM_PCT   = 3'd2;
    localparam logic [2:0] EM_ZERO  = 3'd3;
    localparam logic [2:0] EM_XCH   = 3'd4;
    localparam logic [2:0] EM_MINUS = 3'd5;
    localparam logic [2:0] EM_DIGIT = 3'd6;

    // datapath operation
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_DAB  = 2'd1;
    localparam logic [1:0] OP_EXT  = 2'd2;
    localparam logic [1:0] OP_RD   = 2'd3;

    // sequencing
    localparam logic [2:0] J_NEXT = 3'd0;
    localparam logic [2:0] J_DONE = 3'd1;
    localparam logic [2:0] J_GOTO = 3'd2;
    localparam logic [2:0] J_DAB  = 3'd3;
    localparam logic [2:0] J_EXT  = 3'd4;
    localparam logic [2:0] J_DIG  = 3'd5;

    // number base
    localparam logic [1:0] BK_2  = 2'd0;
    localparam logic [1:0] BK_8  = 2'd1;
    localparam logic [1:0] BK_10 = 2'd2;
    localparam logic [1:0] BK_16 = 2'd3;

    // microcode addresses
    localparam logic [STEP_BITS-1:0] S_ECHO = 4'd0;
    localparam logic [STEP_BITS-1:0] S_PCT  = 4'd1;
    localparam logic [STEP_BITS-1:0] S_CHR  = 4'd2;
    localparam logic [STEP_BITS-1:0] S_NONE = 4'd3;
    localparam logic [STEP_BITS-1:0] S_OCT  = 4'd4;
    localparam logic [STEP_BITS-1:0] S_HEX0 = 4'd5;
    localparam logic [STEP_BITS-1:0] S_HEX1 = 4'd6;
    localparam logic [STEP_BITS-1:0] S_SIGN = 4'd7;
    localparam logic [STEP_BITS-1:0] S_DAB  = 4'd8;
    localparam logic [STEP_BITS-1:0] S_EXT  = 4'd9;
    localparam logic [STEP_BITS-1:0] S_RD   = 4'd10;
    localparam logic [STEP_BITS-1:0] S_DIG  = 4'd11;

    typedef struct packed {
        logic [2:0]           emit;
        logic [1:0]           op;
        logic [2:0]           jmp;
        logic [STEP_BITS-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
        ctrl_t cw;
        cw = '{emit: EM_NONE, op: OP_NONE, jmp: J_DONE, target: S_NONE};
        unique case (step)
            S_ECHO: cw = '{emit: EM_FMT,   op: OP_NONE, jmp: J_DONE, target: S_NONE};
            S_PCT:  cw = '{emit: EM_PCT,   op: OP_NONE, jmp: J_DONE, target: S_NONE};
            S_CHR:  cw = '{emit: EM_FMT,   op: OP_NONE, jmp: J_DONE, target: S_NONE};
            S_NONE: cw = '{emit: EM_NONE,  op: OP_NONE, jmp: J_DONE, target: S_NONE};
            S_OCT:  cw = '{emit: EM_ZERO,  op: OP_NONE, jmp: J_GOTO, target: S_SIGN};
            S_HEX0: cw = '{emit: EM_ZERO,  op: OP_NONE, jmp: J_NEXT, target: S_NONE};
            S_HEX1: cw = '{emit: EM_XCH,   op: OP_NONE, jmp: J_NEXT, target: S_NONE};
            S_SIGN: cw = '{emit: EM_MINUS, op: OP_NONE, jmp: J_NEXT, target: S_NONE};
            S_DAB:  cw = '{emit: EM_NONE,  op: OP_DAB,  jmp: J_DAB,  target: S_NONE};
            S_EXT:  cw = '{emit: EM_NONE,  op: OP_EXT,  jmp: J_EXT,  target: S_NONE};
            S_RD:   cw = '{emit: EM_NONE,  op: OP_RD,   jmp: J_NEXT, target: S_NONE};
            S_DIG:  cw = '{emit: EM_DIGIT, op: OP_RD,   jmp: J_DIG,  target: S_NONE};
            default: cw = '{emit: EM_NONE, op: OP_NONE, jmp: J_DONE, target: S_NONE};
        endcase
        return cw;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'd0, d};
        else
            c = CH_UA + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsif_if.sv =====
// ----------------------------------------------------------------------------
// fsif_if
// Valid/ready channels of the formatter: format beats in, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsif_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fmt_char;
    logic [31:0] arg_word;
    logic        end_of_format;

    modport source (output valid, output fmt_char, output arg_word,
                    output end_of_format, input ready);
    modport sink   (input valid, input fmt_char, input arg_word,
                    input end_of_format, output ready);
endinterface

interface fsif_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        run_last;
    logic [15:0] emitted_count;

    modport source (output valid, output out_char, output run_last,
                    output emitted_count, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input emitted_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/format_string_integer_formatter.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_formatter
// Printf-style integer formatter run by a small microcode sequencer.
//
//   channel   dir  beat payload
//   fmt_in    in   fmt_char, arg_word, end_of_format
//   chr_out   out  out_char, run_last, emitted_count
//
// One format beat is taken when the sequencer is idle; then one microcode
// step per cycle. Echo, %%, %c: 1 step. Numbers: prefix steps, a sign step,
// 1 (or ARG_BITS for decimal, double dabble) conversion steps, N digit
// extraction steps, 1 read step and N emit steps, N = digit count.
// Output stalls freeze the step counter; the output register lets the next
// format beat enter while the last character waits. Reset clears all control.
// ----------------------------------------------------------------------------
`default_nettype none

module format_string_integer_formatter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fsif_in_if.sink     fmt_in,
    fsif_out_if.source  chr_out
);
    import fsif_pkg::*;

    logic                 busy_reg, busy_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [7:0]           fmt_reg, fmt_next;
    logic                 end_reg, end_next;
    logic                 neg_reg, neg_next;
    logic [1:0]           base_reg, base_next;
    logic [WORK_BITS-1:0] work_reg, work_next;
    logic [ARG_BITS-1:0]  mag_reg, mag_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]  dcnt_reg, dcnt_next;
    logic                 pending_reg, pending_next;
    logic [15:0]          total_reg, total_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           ochar_reg, ochar_next;
    logic                 olast_reg, olast_next;
    logic [15:0]          ocount_reg, ocount_next;
    logic [3:0]           rd_reg;

    logic [3:0]           digit_mem [ARG_BITS];

    ctrl_t                cw;
    logic                 in_acc;
    logic [ARG_BITS-1:0]  val;
    logic [ARG_BITS-1:0]  val_neg;
    logic                 d_signed;
    logic                 d_neg;
    logic [1:0]           d_base;
    logic [STEP_BITS-1:0] d_start;
    logic [ARG_BITS-1:0]  d_mag;
    logic                 emits;
    logic                 out_free;
    logic                 adv;
    logic                 fin;
    logic [STEP_BITS-1:0] jump_step;
    logic [WORK_BITS-1:0] dab_adj;
    logic [WORK_BITS-1:0] work_sh;
    logic [3:0]           digit;
    logic [CNT_BITS-1:0]  dcnt_dec;
    logic                 mem_we;
    logic                 mem_re;
    logic [7:0]           ch_sel;
    logic [15:0]          total_inc;

    assign cw       = ucode(step_reg);
    assign in_acc   = fmt_in.valid && fmt_in.ready;
    assign val      = ARG_BITS'(fmt_in.arg_word);
    assign val_neg  = ~val + 1'b1;
    assign out_free = !ovalid_reg || chr_out.ready;
    assign dcnt_dec = dcnt_reg - 1'b1;

    assign fmt_in.ready          = !busy_reg;
    assign chr_out.valid         = ovalid_reg;
    assign chr_out.out_char      = ochar_reg;
    assign chr_out.run_last      = olast_reg;
    assign chr_out.emitted_count = ocount_reg;

    // dispatch decode
    always_comb
    begin
        d_start  = S_ECHO;
        d_signed = 1'b1;
        d_base   = BK_10;
        if (pending_reg)
        begin
            unique case (fmt_in.fmt_char)
                CH_B:    begin d_start = S_SIGN; d_base = BK_2;  end
                CH_D:    begin d_start = S_SIGN; d_base = BK_10; end
                CH_O:    begin d_start = S_OCT;  d_base = BK_8;  end
                CH_UX:   begin d_start = S_HEX0; d_base = BK_16; end
                CH_U:    begin d_start = S_SIGN; d_signed = 1'b0; end
                CH_C:    d_start = S_CHR;
                CH_PCT:  d_start = S_PCT;
                default: d_start = S_NONE;
            endcase
        end
        else if (fmt_in.fmt_char == CH_PCT && !fmt_in.end_of_format)
            d_start = S_NONE;
        d_neg = d_signed && val[ARG_BITS-1];
        d_mag = d_neg ? val_neg : val;
    end

    // double dabble adjust, digit shift
    always_comb
    begin
        logic [3:0] nib;
        dab_adj = '0;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            nib = work_reg[4*i +: 4];
            dab_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
        case (base_reg)
            BK_2:    begin work_sh = work_reg >> 1; digit = {3'd0, work_reg[0]};   end
            BK_8:    begin work_sh = work_reg >> 3; digit = {1'b0, work_reg[2:0]}; end
            default: begin work_sh = work_reg >> 4; digit = work_reg[3:0];         end
        endcase
    end

    // step sequencing
    always_comb
    begin
        fin       = 1'b0;
        jump_step = step_reg + 1'b1;
        case (cw.jmp)
            J_NEXT: jump_step = step_reg + 1'b1;
            J_GOTO: jump_step = cw.target;
            J_DAB:
                if (base_reg == BK_10 && cnt_reg != CNT_BITS'(1))
                    jump_step = step_reg;
            J_EXT:
                if (work_sh != '0)
                    jump_step = step_reg;
            J_DIG:
                if (dcnt_reg != '0)
                    jump_step = step_reg;
                else
                    fin = 1'b1;
            default: fin = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cw.emit)
            EM_FMT:   ch_sel = fmt_reg;
            EM_PCT:   ch_sel = CH_PCT;
            EM_ZERO:  ch_sel = CH_ZERO;
            EM_XCH:   ch_sel = CH_LX;
            EM_MINUS: ch_sel = CH_MINUS;
            EM_DIGIT: ch_sel = digit_char(rd_reg);
            default:  ch_sel = 8'd0;
        endcase
    end

    assign emits     = (cw.emit != EM_NONE) && !(cw.emit == EM_MINUS && !neg_reg);
    assign adv       = busy_reg && (!emits || out_free);
    assign total_inc = (total_reg == 16'hFFFF) ? total_reg : total_reg + 16'd1;
    assign mem_we    = adv && (cw.op == OP_EXT);
    assign mem_re    = adv && (cw.op == OP_RD) && (dcnt_reg != '0);

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        fmt_next     = fmt_reg;
        end_next     = end_reg;
        neg_next     = neg_reg;
        base_next    = base_reg;
        work_next    = work_reg;
        mag_next     = mag_reg;
        cnt_next     = cnt_reg;
        dcnt_next    = dcnt_reg;
        pending_next = pending_reg;
        total_next   = total_reg;
        ovalid_next  = ovalid_reg && !chr_out.ready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        ocount_next  = ocount_reg;

        if (in_acc)
        begin
            busy_next    = 1'b1;
            step_next    = d_start;
            fmt_next     = (d_start == S_CHR) ? fmt_in.arg_word[7:0] : fmt_in.fmt_char;
            end_next     = fmt_in.end_of_format;
            neg_next     = d_neg;
            base_next    = d_base;
            mag_next     = d_mag;
            work_next    = (d_base == BK_10) ? '0 : WORK_BITS'(d_mag);
            cnt_next     = CNT_BITS'(ARG_BITS);
            dcnt_next    = '0;
            pending_next = !pending_reg && fmt_in.fmt_char == CH_PCT
                           && !fmt_in.end_of_format;
        end

        if (adv)
        begin
            step_next = jump_step;
            case (cw.op)
                OP_DAB:
                    if (base_reg == BK_10)
                    begin
                        work_next = {dab_adj[WORK_BITS-2:0], mag_reg[ARG_BITS-1]};
                        mag_next  = mag_reg << 1;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                OP_EXT:
                begin
                    work_next = work_sh;
                    dcnt_next = dcnt_reg + 1'b1;
                end
                OP_RD:
                    if (dcnt_reg != '0)
                        dcnt_next = dcnt_dec;
                default: ;
            endcase
            if (emits)
            begin
                ovalid_next = 1'b1;
                ochar_next  = ch_sel;
                olast_next  = fin;
                ocount_next = total_inc;
                total_next  = total_inc;
            end
            if (fin)
            begin
                busy_next = 1'b0;
                if (end_reg)
                begin
                    total_next   = '0;
                    pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= S_NONE;
            cnt_reg     <= '0;
            dcnt_reg    <= '0;
            pending_reg <= 1'b0;
            total_reg   <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            dcnt_reg    <= dcnt_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_reg    <= fmt_next;
        end_reg    <= end_next;
        neg_reg    <= neg_next;
        base_reg   <= base_next;
        work_reg   <= work_next;
        mag_reg    <= mag_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
        ocount_reg <= ocount_next;
    end

    // digit scratch
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[dcnt_reg[IDX_BITS-1:0]] <= digit;
        if (mem_re)
            rd_reg <= digit_mem[dcnt_dec[IDX_BITS-1:0]];
    end

    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= CNT_BITS'(ARG_BITS))
        else $error("digit count beyond argument width");

    a_idle_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> dcnt_reg == '0)
        else $error("format beat taken with digits outstanding");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && fin |=> !busy_reg)
        else $error("sequencer still busy after final step");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> ocount_reg != 16'd0)
        else $error("character beat with zero count");

endmodule

`default_nettype wire
